/* sv/lahtbl_pkg.sv */
`default_nettype none

package lahtbl_pkg;

   // Field widths of the access, table entry and result words.
   localparam int ADDR_W   = 48;
   localparam int REQ_W    = 6;
   localparam int KIND_W   = 4;
   localparam int CNT_W    = 16;
   localparam int STAMP_W  = 32;
   localparam int SLOT_W   = 4;

   // Packed bus widths; the tdata widths are rounded up to whole bytes.
   localparam int REQ_TDATA_W   = 56;
   localparam int REQ_TUSER_W   = 5;
   localparam int RSP_FIELDS_W  = 1 + SLOT_W + 1 + CNT_W + CNT_W;
   localparam int RSP_TDATA_W   = 40;

   // Defaults for the top-level parameters.
   localparam int ENTRIES_DEFAULT     = 16;
   localparam int LINE_OFFSET_DEFAULT = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic issue;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic issue_last;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

/* sv/lahtbl_ram.sv */
`default_nettype none

module lahtbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/lahtbl_ctrl.sv */
`default_nettype none

module lahtbl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire lahtbl_pkg::status_type  status,
   output lahtbl_pkg::cmd_type          cmd
);

   import lahtbl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last entry read is compared in this cycle.
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/lahtbl_datapath.sv */
`default_nettype none

module lahtbl_datapath #(
   parameter int ENTRIES          = lahtbl_pkg::ENTRIES_DEFAULT,
   parameter int LINE_OFFSET_BITS = lahtbl_pkg::LINE_OFFSET_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lahtbl_pkg::cmd_type                 cmd,
   output lahtbl_pkg::status_type                   status,
   input  wire logic [lahtbl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [lahtbl_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [lahtbl_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import lahtbl_pkg::*;

   localparam int LINE_W    = ADDR_W - LINE_OFFSET_BITS;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int STAMP_LO  = 0;
   localparam int WRITES_LO = STAMP_LO + STAMP_W;
   localparam int READS_LO  = WRITES_LO + CNT_W;
   localparam int KIND_LO   = READS_LO + CNT_W;
   localparam int REQ_LO    = KIND_LO + KIND_W;
   localparam int LINE_LO   = REQ_LO + REQ_W;
   localparam int ENTRY_W   = LINE_LO + LINE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? COUNT_MAX : CNT_W'(v + 1'b1);
   endfunction

   // Captured access.
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic               wr_ff, wr_in;

   // Scan state.
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]   hit_reads_ff, hit_reads_in;
   logic [CNT_W-1:0]   hit_writes_ff, hit_writes_in;
   logic               inv_found_ff, inv_found_in;
   logic [IDX_W-1:0]   inv_idx_ff, inv_idx_in;
   logic [IDX_W-1:0]   lru_idx_ff, lru_idx_in;
   logic [STAMP_W-1:0] lru_stamp_ff, lru_stamp_in;

   // Table state held in flops.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Entry memory.
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic [LINE_W-1:0]  rd_line;
   logic [STAMP_W-1:0] rd_stamp;
   logic [CNT_W-1:0]   rd_reads;
   logic [CNT_W-1:0]   rd_writes;
   logic               rd_valid;

   // Update terms.
   logic [IDX_W-1:0]        slot_idx;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic                    evicted;
   logic [CNT_W-1:0]        new_reads;
   logic [CNT_W-1:0]        new_writes;

   assign rd_line   = rd_data[LINE_LO +: LINE_W];
   assign rd_stamp  = rd_data[STAMP_LO +: STAMP_W];
   assign rd_reads  = rd_data[READS_LO +: CNT_W];
   assign rd_writes = rd_data[WRITES_LO +: CNT_W];
   assign rd_valid  = valid_ff[cmp_idx_ff];

   always_comb begin
      if (hit_found_ff) begin
         slot_idx   = hit_idx_ff;
         evicted    = 1'b0;
         new_reads  = wr_ff ? hit_reads_ff : sat_inc(hit_reads_ff);
         new_writes = wr_ff ? sat_inc(hit_writes_ff) : hit_writes_ff;
      end else begin
         // A free entry wins over the least recently used one.
         slot_idx   = inv_found_ff ? inv_idx_ff : lru_idx_ff;
         evicted    = !inv_found_ff;
         new_reads  = wr_ff ? '0 : CNT_W'(1);
         new_writes = wr_ff ? CNT_W'(1) : '0;
      end
   end

   assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};
   assign wr_data  = {line_ff, req_ff, kind_ff, new_reads, new_writes, clock_ff};

   always_comb begin
      line_in       = line_ff;
      req_in        = req_ff;
      kind_in       = kind_ff;
      wr_in         = wr_ff;
      cnt_in        = cnt_ff;
      cmp_valid_in  = cmd.issue;
      cmp_idx_in    = cnt_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_reads_in  = hit_reads_ff;
      hit_writes_in = hit_writes_ff;
      inv_found_in  = inv_found_ff;
      inv_idx_in    = inv_idx_ff;
      lru_idx_in    = lru_idx_ff;
      lru_stamp_in  = lru_stamp_ff;
      valid_in      = valid_ff;
      clock_in      = clock_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.capture) begin
         line_in      = req_tdata[LINE_OFFSET_BITS +: LINE_W];
         req_in       = req_tdata[ADDR_W +: REQ_W];
         kind_in      = req_tuser[KIND_W-1:0];
         wr_in        = req_tuser[KIND_W];
         cnt_in       = '0;
         hit_found_in = 1'b0;
         inv_found_in = 1'b0;
      end

      if (cmd.issue) begin
         cnt_in = IDX_W'(cnt_ff + 1'b1);
      end

      if (cmp_valid_ff) begin
         if (rd_valid && (rd_line == line_ff) && !hit_found_ff) begin
            hit_found_in  = 1'b1;
            hit_idx_in    = cmp_idx_ff;
            hit_reads_in  = rd_reads;
            hit_writes_in = rd_writes;
         end
         if (!rd_valid && !inv_found_ff) begin
            inv_found_in = 1'b1;
            inv_idx_in   = cmp_idx_ff;
         end
         // The oldest stamp is only used when every entry is valid.
         if ((cmp_idx_ff == '0) || (rd_stamp < lru_stamp_ff)) begin
            lru_idx_in   = cmp_idx_ff;
            lru_stamp_in = rd_stamp;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.commit) begin
         valid_in[slot_idx] = 1'b1;
         clock_in           = STAMP_W'(clock_ff + 1'b1);
         rsp_valid_in       = 1'b1;
         rsp_data_in        = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, new_writes, new_reads,
                               evicted, slot_ext[SLOT_W-1:0], hit_found_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmp_valid_in;
         valid_ff     <= valid_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff       <= line_in;
      req_ff        <= req_in;
      kind_ff       <= kind_in;
      wr_ff         <= wr_in;
      cnt_ff        <= cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_reads_ff  <= hit_reads_in;
      hit_writes_ff <= hit_writes_in;
      inv_found_ff  <= inv_found_in;
      inv_idx_ff    <= inv_idx_in;
      lru_idx_ff    <= lru_idx_in;
      lru_stamp_ff  <= lru_stamp_in;
      rsp_data_ff   <= rsp_data_in;
   end

   lahtbl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (slot_idx),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign status.issue_last = (cnt_ff == LAST_IDX);
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_commit_not_blocked: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("entry committed while the result register is still occupied");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed access produced no result word");

   a_clock_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (clock_ff == STAMP_W'($past(clock_ff) + 1'b1)))
      else $error("access clock did not advance on commit");

   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      hit_found_ff |-> valid_ff[hit_idx_ff])
      else $error("hit recorded on an entry that is not valid");
`endif

endmodule

`default_nettype wire

/* sv/line_access_history_table_core.sv */
// Each access word is scanned against every entry and written back, and then its result
// word is offered. No new access word is taken until the last is written back, since
// the scan reads one entry per cycle from the single entry memory read port.
// A waiting result word holds the block in its write cycle until the consumer takes one.
// Reset (synchronous, active high) clears all valid bits, the access clock and the
// controller at once; entry contents stay unknown until an entry is first written.
`default_nettype none

module line_access_history_table_core #(
   parameter int ENTRIES          = lahtbl_pkg::ENTRIES_DEFAULT,
   parameter int LINE_OFFSET_BITS = lahtbl_pkg::LINE_OFFSET_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Access words.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0: byte_address[47:0], requester_id[53:48], zero fill[55:54].
   input  wire logic [lahtbl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: request_kind[3:0], is_write[4].
   input  wire logic [lahtbl_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Result words.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // Fields from bit 0: hit[0], slot[4:1], evicted_valid[5], read_total[21:6],
   // write_total[37:22], zero fill[39:38].
   output logic      [lahtbl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import lahtbl_pkg::*;

   // The controller sequences each access through four phases: it takes the word,
   // walks every entry of the table, lets the last entry read settle into the
   // comparators, and then writes the chosen entry back while loading the result
   // register. The datapath keeps the table entries in a memory and the valid bits
   // and access clock in flops.
   //
   // During the walk each entry is checked for a line match (the first valid match
   // is the hit), for being free (the first free entry is remembered) and for its
   // use stamp (the oldest stamp, lowest index on ties, is remembered). A miss takes
   // the free entry if there is one and otherwise the oldest one. Every access
   // stamps its entry with the running access clock, which wraps around.
   //
   // The result register sits between the table and the consumer, so the next access
   // word can be taken and scanned while an earlier result word is still waiting.

   cmd_type    cmd;
   status_type status;

   lahtbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lahtbl_datapath #(
      .ENTRIES          (ENTRIES),
      .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* sim/line_access_history_table_checker.sv */
module line_access_history_table_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   // Fields from bit 0: byte_address[47:0], requester_id[53:48], zero fill[55:54].
   input  wire logic [lahtbl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: request_kind[3:0], is_write[4].
   input  wire logic [lahtbl_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // Fields from bit 0: hit[0], slot[4:1], evicted_valid[5], read_total[21:6],
   // write_total[37:22], zero fill[39:38].
   input  wire logic [lahtbl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                                      mismatch_count,
   output int                                      awaited_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRY_COUNT = lahtbl_pkg::ENTRIES_DEFAULT;
   localparam int LINE_SHIFT  = lahtbl_pkg::LINE_OFFSET_DEFAULT;
   localparam int LINE_W      = lahtbl_pkg::ADDR_W - LINE_SHIFT;
   localparam int CNT_W       = lahtbl_pkg::CNT_W;

   // Laid out so that the first field sits in bit 0, as on the result bus.
   typedef struct packed {
      logic [CNT_W-1:0]              writes;
      logic [CNT_W-1:0]              reads;
      logic                          evicted;
      logic [lahtbl_pkg::SLOT_W-1:0] slot;
      logic                          hit;
   } lookup_result_type;

   logic                               tracked        [ENTRY_COUNT];
   logic [LINE_W-1:0]                  tracked_line   [ENTRY_COUNT];
   logic [lahtbl_pkg::REQ_W-1:0]       last_requester [ENTRY_COUNT];
   logic [lahtbl_pkg::KIND_W-1:0]      last_kind      [ENTRY_COUNT];
   logic [CNT_W-1:0]                   read_count     [ENTRY_COUNT];
   logic [CNT_W-1:0]                   write_count    [ENTRY_COUNT];
   logic [lahtbl_pkg::STAMP_W-1:0]     use_stamp      [ENTRY_COUNT];
   logic [lahtbl_pkg::STAMP_W-1:0]     access_counter;
   lookup_result_type                  predicted_lookups[$];

   initial mismatch_count = 0;

   function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] value);
      return (value == {CNT_W{1'b1}}) ? value : value + 1'b1;
   endfunction

   // Looks the line up, applies the access to the shadow table and returns the result word.
   function automatic lookup_result_type lookup_and_update(
      input logic [lahtbl_pkg::ADDR_W-1:0] byte_addr,
      input logic [lahtbl_pkg::REQ_W-1:0]  requester,
      input logic [lahtbl_pkg::KIND_W-1:0] kind,
      input logic                          is_write
   );
      lookup_result_type              res;
      logic [LINE_W-1:0]              line_key;
      logic                           found;
      logic                           have_free;
      logic [lahtbl_pkg::STAMP_W-1:0] oldest;
      int                             idx;
      line_key  = LINE_W'(byte_addr >> LINE_SHIFT);
      found     = 1'b0;
      have_free = 1'b0;
      idx       = 0;
      res       = '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (!found && tracked[i] && tracked_line[i] == line_key) begin
            found = 1'b1;
            idx   = i;
         end
      end
      if (found) begin
         if (is_write) begin
            write_count[idx] = bump_count(write_count[idx]);
         end else begin
            read_count[idx] = bump_count(read_count[idx]);
         end
      end else begin
         // First free entry wins; with none free, the oldest stamp, lowest index on a tie.
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (!have_free && !tracked[i]) begin
               have_free = 1'b1;
               idx       = i;
            end
         end
         if (!have_free) begin
            oldest = use_stamp[0];
            for (int i = 1; i < ENTRY_COUNT; i++) begin
               if (use_stamp[i] < oldest) begin
                  oldest = use_stamp[i];
                  idx    = i;
               end
            end
         end
         res.evicted       = tracked[idx];
         tracked[idx]      = 1'b1;
         tracked_line[idx] = line_key;
         read_count[idx]   = is_write ? '0 : CNT_W'(1);
         write_count[idx]  = is_write ? CNT_W'(1) : '0;
      end
      last_requester[idx] = requester;
      last_kind[idx]      = kind;
      use_stamp[idx]      = access_counter;
      access_counter      = access_counter + 1'b1;
      res.hit    = found;
      res.slot   = idx[lahtbl_pkg::SLOT_W-1:0];
      res.reads  = read_count[idx];
      res.writes = write_count[idx];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      lookup_result_type got;
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) tracked[i] = 1'b0;
         access_counter = '0;
         predicted_lookups.delete();
      end else begin
         // Compare before queueing, so a stray word is never matched to a fresh access.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[lahtbl_pkg::RSP_FIELDS_W-1:0];
            if (predicted_lookups.size() == 0) begin
               report_mismatch("result word with no access pending", rsp_tdata, '0);
            end else begin
               want = predicted_lookups.pop_front();
               if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
               if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
               if (got.evicted !== want.evicted)
                  report_mismatch("evicted_valid", got.evicted, want.evicted);
               if (got.reads !== want.reads)
                  report_mismatch("read_total", got.reads, want.reads);
               if (got.writes !== want.writes)
                  report_mismatch("write_total", got.writes, want.writes);
            end
         end
         if (req_tvalid && req_tready) begin
            predicted_lookups.push_back(lookup_and_update(req_tdata[47:0], req_tdata[53:48],
                                                          req_tuser[3:0], req_tuser[4]));
         end
      end
      awaited_results <= predicted_lookups.size();
   end

endmodule

/* sim/line_access_history_table_core_tb.sv */
module line_access_history_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD       = 6;
   localparam int RESET_CYCLES      = 8;
   localparam int SCAN_CYCLES       = lahtbl_pkg::ENTRIES_DEFAULT + 3;
   localparam int LINE_W            = lahtbl_pkg::ADDR_W - lahtbl_pkg::LINE_OFFSET_DEFAULT;
   localparam int HOT_LINES         = 20;
   localparam int RSP_HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT       = 5000;
   localparam int DRAIN_CYCLES      = 4 * SCAN_CYCLES;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [lahtbl_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [lahtbl_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [lahtbl_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int awaited_results;
   int quiet_cycles = 0;

   // Traffic shaping knobs, flipped by the stimulus between phases.
   bit sender_idles     = 1'b1;
   bit receiver_idles   = 1'b1;
   bit rsp_hold_request = 1'b0;

   // A small pool of lines, a few more than the table holds, so that random traffic
   // produces a healthy mix of hits, fills and LRU evictions.
   logic [LINE_W-1:0] hot_lines [HOT_LINES];

   always #(HALF_PERIOD) clock = ~clock;

   line_access_history_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   line_access_history_table_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .awaited_results (awaited_results)
   );

   // Offers one access word and returns at the edge where it is taken. The valid stays
   // high on return, so back-to-back words never drop it within a single time step.
   // A gap, when one is drawn, can span a whole scan so it lands on every phase.
   task automatic send_access(input logic [lahtbl_pkg::ADDR_W-1:0] byte_addr,
                              input logic [lahtbl_pkg::REQ_W-1:0]  requester,
                              input logic [lahtbl_pkg::KIND_W-1:0] kind,
                              input logic                          is_write);
      if (sender_idles && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(2 * SCAN_CYCLES, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, requester, byte_addr};
      req_tuser  <= {is_write, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly lines from the hot pool, sometimes retiring a pool line for a fresh one,
   // and sometimes a completely random line that will almost surely miss.
   task automatic random_access();
      logic [LINE_W-1:0] chosen_line;
      int                pick;
      int                slot_pick;
      pick      = $urandom_range(99);
      slot_pick = $urandom_range(HOT_LINES - 1);
      if (pick < 70) begin
         chosen_line = hot_lines[slot_pick];
      end else if (pick < 80) begin
         hot_lines[slot_pick] = LINE_W'({$urandom(), $urandom()});
         chosen_line = hot_lines[slot_pick];
      end else begin
         chosen_line = LINE_W'({$urandom(), $urandom()});
      end
      send_access({chosen_line, 6'($urandom())}, 6'($urandom()), 4'($urandom()),
                  1'($urandom()));
   endtask

   // Lets every predicted result word come back before going on.
   task automatic wait_for_results();
      do @(posedge clock); while (awaited_results != 0);
   endtask

   // Result consumer. Besides the random back-pressure it can hold off for a long
   // stretch on request, which lets the block fill up and stall its access input.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= !(receiver_idles && $urandom_range(99) < 22);
         end
      end
   end

   // Watchdog: a run that stops moving words on both channels for too long is a failure.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < HOT_LINES; i++) hot_lines[i] = LINE_W'({$urandom(), $urandom()});
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first line is address zero; the offset bits must not matter,
      // so the second word hits it through the highest offset with extreme field values.
      send_access(48'h0, 6'd0, 4'd0, 1'b0);
      send_access(48'h3F, 6'd63, 4'd15, 1'b1);
      send_access(48'h0, 6'h2A, 4'h5, 1'b0);
      // The highest line, missed and then hit from its lowest byte.
      send_access(48'hFFFF_FFFF_FFFF, 6'h15, 4'hA, 1'b0);
      send_access(48'hFFFF_FFFF_FFC0, 6'd63, 4'd15, 1'b1);
      // The neighbor of line zero is a different line; a first write leaves reads at zero.
      send_access(48'h40, 6'd0, 4'd0, 1'b1);
      // Fill the rest of the table with distinct lines.
      for (int i = 3; i < lahtbl_pkg::ENTRIES_DEFAULT; i++) begin
         send_access({42'h2AA_AAAA_AAAA ^ LINE_W'(i), 6'(i * 5)}, 6'(i * 4), 4'(i), 1'(i));
      end
      // Refresh line zero, then force evictions: each miss must take the least recently
      // used entry, and the evicted highest line has to come back as a fresh miss.
      send_access(48'h10, 6'd7, 4'd3, 1'b1);
      send_access(48'h1234_5678_9AC0, 6'd9, 4'd6, 1'b0);
      send_access(48'h80, 6'd11, 4'd12, 1'b1);
      send_access(48'hFFFF_FFFF_FFFF, 6'd1, 4'd1, 1'b0);
      send_access(48'h0, 6'd2, 4'd2, 1'b0);

      // Random traffic with idling on both sides.
      repeat (500) random_access();

      // Long receiver hold-off while accesses keep coming.
      rsp_hold_request = 1'b1;
      repeat (12) random_access();

      // A long stretch at full speed on both sides.
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (300) random_access();

      // The sender pauses until the pipeline is empty.
      req_tvalid <= 1'b0;
      wait_for_results();

      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (720) random_access();

      req_tvalid <= 1'b0;
      wait_for_results();
      // Give a stray extra result word time to show up and be flagged.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
